### rtl/mrr_pkg.sv
package mrr_pkg;

    // Frame limits
    localparam int MAX_FRAME_BYTES = 256;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

    // Modbus CRC-16
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Body positions of the header fields
    localparam logic [15:0] POS_ID       = 16'd0;
    localparam logic [15:0] POS_FCODE    = 16'd1;
    localparam logic [15:0] POS_START_HI = 16'd2;
    localparam logic [15:0] POS_START_LO = 16'd3;
    localparam logic [15:0] POS_COUNT_HI = 16'd4;
    localparam logic [15:0] POS_COUNT_LO = 16'd5;
    localparam logic [15:0] POS_BYTECNT  = 16'd6;
    localparam logic [15:0] HEADER_LEN   = 16'd6;
    localparam logic [15:0] DATA_START   = 16'd7;

    localparam logic [7:0] FC_WRITE_COILS = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Summary status codes
    localparam logic [2:0] ST_GOOD      = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_CRC_ERR   = 3'd2;
    localparam logic [2:0] ST_TOO_SHORT = 3'd3;
    localparam logic [2:0] ST_NOT_ADDR  = 3'd4;
    localparam logic [2:0] ST_BAD_REQ   = 3'd5;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_OWN_ADDRESS = 1'b0;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [2:0]  status;
        logic [7:0]  slave_id;
        logic [7:0]  function_code;
        logic [15:0] start_register;
        logic [15:0] register_count;
        logic [7:0]  data_length;
        logic        last;
    } out_item_t;

    // Queue write strobes for the two result slots of one byte
    typedef struct packed {
        logic wr0;
        logic wr1;
    } res_wr_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/mrr_frame.sv
module mrr_frame (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  mrr_pkg::in_item_t  item,
    input  logic [7:0]         own_address,
    output mrr_pkg::res_wr_t   wr,
    output mrr_pkg::out_item_t res0,
    output mrr_pkg::out_item_t res1
);
    import mrr_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_upd;
    logic [15:0]      delay_reg, delay_next, delay_upd;
    logic [15:0]      crc_reg, crc_next, crc_upd;
    logic [7:0]       id_reg, id_next, id_upd;
    logic [7:0]       fcode_reg, fcode_next, fcode_upd;
    logic [15:0]      start_reg, start_next, start_upd;
    logic [15:0]      count_reg, count_next, count_upd;
    logic [7:0]       bcnt_reg, bcnt_next, bcnt_upd;
    logic             ovf_reg, ovf_next, ovf_upd;

    logic [7:0]  e;
    logic [15:0] p16;
    logic [15:0] didx;
    logic        pay_vld;
    logic [15:0] body;
    logic [15:0] present;
    logic [15:0] rx_crc;
    logic        fc_ok;
    logic [2:0]  st;
    logic [7:0]  dl;
    out_item_t   pay_res, sum_res;

    // Byte leaving the delay line feeds CRC and header
    always_comb begin
        cnt_upd   = cnt_reg;
        delay_upd = delay_reg;
        crc_upd   = crc_reg;
        id_upd    = id_reg;
        fcode_upd = fcode_reg;
        start_upd = start_reg;
        count_upd = count_reg;
        bcnt_upd  = bcnt_reg;
        ovf_upd   = ovf_reg;
        pay_vld   = 1'b0;
        e         = delay_reg[15:8];
        p16       = 16'(cnt_reg) - 16'd2;
        didx      = p16 - DATA_START;
        if (!ovf_reg) begin
            if (cnt_reg >= CNT_W'(2)) begin
                crc_upd = crc16_byte(crc_reg, e);
                case (p16)
                    POS_ID:       id_upd = e;
                    POS_FCODE:    fcode_upd = e;
                    POS_START_HI: start_upd = {e, start_reg[7:0]};
                    POS_START_LO: start_upd = {start_reg[15:8], e};
                    POS_COUNT_HI: count_upd = {e, count_reg[7:0]};
                    POS_COUNT_LO: count_upd = {count_reg[15:8], e};
                    POS_BYTECNT:  bcnt_upd = e;
                    default:      pay_vld = didx < {8'h00, bcnt_reg};
                endcase
            end
            delay_upd = {delay_reg[7:0], item.rx_byte};
            cnt_upd   = cnt_reg + CNT_W'(1);
            ovf_upd   = 16'(cnt_upd) >= 16'(MAX_FRAME_BYTES);
        end
    end

    // Frame summary from the updated state
    always_comb begin
        body    = 16'(cnt_upd) - 16'd2;
        present = body - DATA_START;
        rx_crc  = {delay_upd[7:0], delay_upd[15:8]};
        fc_ok   = (fcode_upd == FC_WRITE_COILS) || (fcode_upd == FC_WRITE_REGS);
        dl      = 8'h00;
        if (ovf_upd) begin
            st = ST_OVERFLOW;
        end else if (cnt_upd < CNT_W'(2)) begin
            st = ST_TOO_SHORT;
        end else begin
            if (rx_crc != crc_upd) begin
                st = ST_CRC_ERR;
            end else if (body < HEADER_LEN) begin
                st = ST_TOO_SHORT;
            end else if (id_upd != 8'h00 && id_upd != own_address) begin
                st = ST_NOT_ADDR;
            end else if (body > HEADER_LEN && !fc_ok) begin
                st = ST_BAD_REQ;
            end else begin
                st = ST_GOOD;
            end
            if (body > HEADER_LEN && fc_ok) begin
                dl = ({8'h00, bcnt_upd} > present) ? present[7:0] : bcnt_upd;
            end
        end
    end

    always_comb begin
        pay_res               = '0;
        pay_res.kind          = KIND_PAYLOAD;
        pay_res.payload_byte  = e;
        pay_res.payload_index = didx[7:0];
        pay_res.last          = !item.frame_end;

        sum_res                = '0;
        sum_res.kind           = KIND_SUMMARY;
        sum_res.status         = st;
        sum_res.slave_id       = id_upd;
        sum_res.function_code  = fcode_upd;
        sum_res.start_register = start_upd;
        sum_res.register_count = count_upd;
        sum_res.data_length    = dl;
        sum_res.last           = 1'b1;

        res0   = pay_vld ? pay_res : sum_res;
        res1   = sum_res;
        wr.wr0 = step && (pay_vld || item.frame_end);
        wr.wr1 = step && pay_vld && item.frame_end;
    end

    // End of frame clears everything for the next one
    always_comb begin
        cnt_next   = cnt_reg;
        delay_next = delay_reg;
        crc_next   = crc_reg;
        id_next    = id_reg;
        fcode_next = fcode_reg;
        start_next = start_reg;
        count_next = count_reg;
        bcnt_next  = bcnt_reg;
        ovf_next   = ovf_reg;
        if (step) begin
            if (item.frame_end) begin
                cnt_next   = '0;
                delay_next = '0;
                crc_next   = CRC_INIT;
                id_next    = '0;
                fcode_next = '0;
                start_next = '0;
                count_next = '0;
                bcnt_next  = '0;
                ovf_next   = 1'b0;
            end else begin
                cnt_next   = cnt_upd;
                delay_next = delay_upd;
                crc_next   = crc_upd;
                id_next    = id_upd;
                fcode_next = fcode_upd;
                start_next = start_upd;
                count_next = count_upd;
                bcnt_next  = bcnt_upd;
                ovf_next   = ovf_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            delay_reg <= '0;
            crc_reg   <= CRC_INIT;
            id_reg    <= '0;
            fcode_reg <= '0;
            start_reg <= '0;
            count_reg <= '0;
            bcnt_reg  <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            delay_reg <= delay_next;
            crc_reg   <= crc_next;
            id_reg    <= id_next;
            fcode_reg <= fcode_next;
            start_reg <= start_next;
            count_reg <= count_next;
            bcnt_reg  <= bcnt_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

### rtl/mrr_result_fifo.sv
module mrr_result_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  mrr_pkg::res_wr_t   wr,
    input  mrr_pkg::out_item_t res0,
    input  mrr_pkg::out_item_t res1,
    output logic               room2,
    output logic               m_valid,
    input  logic               m_ready,
    output mrr_pkg::out_item_t m_item
);
    import mrr_pkg::*;

    out_item_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               pop;
    logic [FIFO_CW-1:0] push_n;

    assign m_valid = count_reg != '0;
    assign m_item  = mem_reg[rd_ptr_reg];
    assign room2   = count_reg <= FIFO_CW'(FIFO_DEPTH - 2);
    assign pop     = m_valid && m_ready;
    assign push_n  = FIFO_CW'(wr.wr0) + FIFO_CW'(wr.wr1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_n);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + push_n - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.wr0) begin
            mem_reg[wr_ptr_reg] <= res0;
        end
        if (wr.wr1) begin
            mem_reg[wr_ptr_reg + FIFO_AW'(1)] <= res1;
        end
    end

endmodule

### rtl/modbus_rtu_request_receiver.sv
// Channel  | Ports               | Carries
// ---------+---------------------+-----------------------------------------------
// input    | s_valid/s_ready     | s_item: rx_byte, frame_end (one received byte)
// result   | m_valid/m_ready     | m_item: payload byte or frame summary
// config   | psel/penable/pwrite | own_address at byte address 0
//
// One byte per cycle while the result side keeps up; a byte that ends a frame
// and also releases a data byte puts two results into the queue, which drains
// one per cycle. Input stalls only while the queue holds more than two.
// Path: input register, then the frame logic writes the result queue,
// which drives m_item.
// Reset (aresetn low, synchronous) clears frame state, own_address = 1.
// s_ready depends only on local registers, never on m_ready.
module modbus_rtu_request_receiver (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input byte channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mrr_pkg::in_item_t             s_item,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output mrr_pkg::out_item_t            m_item,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mrr_pkg::PADDR_W-1:0]   paddr,
    input  logic [mrr_pkg::PDATA_W-1:0]   pwdata,
    output logic [mrr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import mrr_pkg::*;

    // Configuration register
    logic [7:0] own_addr_reg, own_addr_next;
    logic       reg_sel;
    logic       cfg_wr;

    // Input register in front of the frame logic
    in_item_t   in_item_reg, in_item_next;
    logic       in_vld_reg, in_vld_next;
    logic       s_xfer;
    logic       step;

    // Between frame logic and result queue
    res_wr_t    wr;
    out_item_t  res0, res1;
    logic       room2;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1] == REG_OWN_ADDRESS;
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? {{(PDATA_W - 8){1'b0}}, own_addr_reg} : '0;

    always_comb begin
        own_addr_next = cfg_wr ? pwdata[7:0] : own_addr_reg;
    end

    // A byte is worked on only when the queue can take two results
    assign step    = in_vld_reg && room2;
    assign s_ready = !in_vld_reg || step;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        in_item_next = s_xfer ? s_item : in_item_reg;
        in_vld_next  = s_xfer ? 1'b1 : (step ? 1'b0 : in_vld_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_addr_reg <= 8'd1;
            in_vld_reg   <= 1'b0;
        end else begin
            own_addr_reg <= own_addr_next;
            in_vld_reg   <= in_vld_next;
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
    end

    mrr_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .item        (in_item_reg),
        .own_address (own_addr_reg),
        .wr          (wr),
        .res0        (res0),
        .res1        (res1)
    );

    mrr_result_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .res0    (res0),
        .res1    (res1),
        .room2   (room2),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

### bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrr_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports
    // ------------------------------------------------------------------
    logic               aclk;
    logic               aresetn = 1'b0;

    logic               s_valid = 1'b0;
    logic               s_ready;
    in_item_t           s_item  = '0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    out_item_t          m_item;

    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // own_address sits at byte offset 4 * register index
    localparam logic [PADDR_W-1:0] OWN_ADDR_OFFSET = PADDR_W'(4 * int'(REG_OWN_ADDRESS));

    // Traffic phases: address setting, sender idle and receiver stall in percent.
    // The last phase picks a random in-range address at run time.
    localparam int N_PHASES     = 5;
    localparam int PHASE_BYTES  = 120;
    localparam int OVF_PHASE    = 3;   // phase that opens with an overflowing frame
    localparam int HOLD_PHASE   = 0;   // phase with the long receiver hold-off
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_CYCLES = 8;   // margin for bytes still in the pipe
    int own_plan  [N_PHASES] = '{247, 1, 0, 255, 0};
    int send_plan [N_PHASES] = '{0, 83, 0, 14, 0};
    int recv_plan [N_PHASES] = '{0, 0, 83, 14, 0};

    modbus_rtu_request_receiver u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop in case a transfer never completes.
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Frame predictor: mirrors the receiver's frame state byte by byte
    // ------------------------------------------------------------------
    logic [7:0]  own_addr  = 8'd1;
    logic [15:0] f_crc     = CRC_INIT;  // CRC over bytes out of the two-byte delay
    int          f_cnt     = 0;         // bytes taken in this frame
    logic [15:0] f_tail    = '0;        // last two bytes, older one in the high byte
    logic [7:0]  f_id      = '0;
    logic [7:0]  f_fcode   = '0;
    logic [15:0] f_start   = '0;
    logic [15:0] f_count   = '0;
    logic [7:0]  f_bytecnt = '0;
    logic        f_ovf     = 1'b0;

    out_item_t   fresh_results[$];      // produced by the byte just transferred
    out_item_t   awaited_results[$];    // in flight, oldest first

    // Stats and error tracking
    int n_errors    = 0;
    int n_bytes     = 0;
    int n_frames    = 0;
    int n_payloads  = 0;
    int n_summaries = 0;
    int status_hits [0:5] = '{default: 0};

    // Traffic knobs, set by the stimulus process per phase
    int send_idle     = 0;
    int recv_stall    = 0;
    int phase_no      = -1;
    int hold_left     = 0;
    bit pressure_done = 1'b0;

    // Modbus CRC-16, shifted one message bit at a time (LSB first)
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ d[i];
            c  = {1'b0, c[15:1]};
            if (fb) c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic fe);
        out_item_t   r;
        logic [7:0]  e;
        logic [15:0] p;
        logic [15:0] rx_crc;
        logic        fc_ok;
        int          body;
        if (!f_ovf) begin
            // byte leaving the delay line is known not to be CRC
            if (f_cnt >= 2) begin
                e     = f_tail[15:8];
                p     = 16'(f_cnt - 2);
                f_crc = crc16_step(f_crc, e);
                case (p)
                    POS_ID:       f_id           = e;
                    POS_FCODE:    f_fcode        = e;
                    POS_START_HI: f_start[15:8]  = e;
                    POS_START_LO: f_start[7:0]   = e;
                    POS_COUNT_HI: f_count[15:8]  = e;
                    POS_COUNT_LO: f_count[7:0]   = e;
                    POS_BYTECNT:  f_bytecnt      = e;
                    default: begin
                        // data field, only up to the declared byte count
                        if (p - DATA_START < {8'h00, f_bytecnt}) begin
                            r               = '0;
                            r.kind          = KIND_PAYLOAD;
                            r.payload_byte  = e;
                            r.payload_index = 8'(p - DATA_START);
                            fresh_results.push_back(r);
                        end
                    end
                endcase
            end
            f_tail = {f_tail[7:0], b};
            f_cnt++;
            if (f_cnt >= MAX_FRAME_BYTES) f_ovf = 1'b1;
        end

        if (fe) begin
            r                = '0;
            r.kind           = KIND_SUMMARY;
            r.slave_id       = f_id;
            r.function_code  = f_fcode;
            r.start_register = f_start;
            r.register_count = f_count;
            fc_ok = (f_fcode == FC_WRITE_COILS) || (f_fcode == FC_WRITE_REGS);
            if (f_ovf) begin
                r.status = ST_OVERFLOW;
            end else if (f_cnt < 2) begin
                r.status = ST_TOO_SHORT;
            end else begin
                body   = f_cnt - 2;
                // CRC travels low byte first
                rx_crc = {f_tail[7:0], f_tail[15:8]};
                if (rx_crc != f_crc)                       r.status = ST_CRC_ERR;
                else if (body < int'(HEADER_LEN))          r.status = ST_TOO_SHORT;
                else if (f_id != 8'd0 && f_id != own_addr) r.status = ST_NOT_ADDR;
                else if (body > int'(HEADER_LEN) && !fc_ok) r.status = ST_BAD_REQ;
                else                                       r.status = ST_GOOD;
                // declared byte count clamped to the data actually present
                if (body > int'(HEADER_LEN) && fc_ok) begin
                    if (int'(f_bytecnt) > body - int'(DATA_START))
                        r.data_length = 8'(body - int'(DATA_START));
                    else
                        r.data_length = f_bytecnt;
                end
            end
            fresh_results.push_back(r);
            // fresh frame
            f_crc     = CRC_INIT;
            f_cnt     = 0;
            f_tail    = '0;
            f_id      = '0;
            f_fcode   = '0;
            f_start   = '0;
            f_count   = '0;
            f_bytecnt = '0;
            f_ovf     = 1'b0;
        end

        if (fresh_results.size() != 0) begin
            r      = fresh_results.pop_back();
            r.last = 1'b1;
            fresh_results.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Reporting helpers
    // ------------------------------------------------------------------
    function automatic void note_mismatch(input string msg);
        n_errors++;
        if (n_errors <= 10) $display("MISMATCH @%0t: %s", $time, msg);
    endfunction

    function automatic string show_item(input out_item_t r);
        string s;
        s = $sformatf("{kind %0d byte %02h idx %0d st %0d id %02h fc %02h",
                      r.kind, r.payload_byte, r.payload_index, r.status, r.slave_id,
                      r.function_code);
        return {s, $sformatf(" sr %04h rc %04h dl %0d last %0d}",
                             r.start_register, r.register_count, r.data_length, r.last)};
    endfunction

    function automatic string diff_fields(input out_item_t w, input out_item_t g);
        string s = "";
        if (g.kind           !== w.kind)           s = {s, " kind"};
        if (g.payload_byte   !== w.payload_byte)   s = {s, " payload_byte"};
        if (g.payload_index  !== w.payload_index)  s = {s, " payload_index"};
        if (g.status         !== w.status)         s = {s, " status"};
        if (g.slave_id       !== w.slave_id)       s = {s, " slave_id"};
        if (g.function_code  !== w.function_code)  s = {s, " function_code"};
        if (g.start_register !== w.start_register) s = {s, " start_register"};
        if (g.register_count !== w.register_count) s = {s, " register_count"};
        if (g.data_length    !== w.data_length)    s = {s, " data_length"};
        if (g.last           !== w.last)           s = {s, " last"};
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Result side: check each transfer, then pick next m_ready.
    // The long hold-off lets the result queue fill and back up s_ready.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_side
        out_item_t want;
        string     bad;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                note_mismatch($sformatf("result with nothing pending: %s", show_item(m_item)));
            end else begin
                want = awaited_results.pop_front();
                bad  = diff_fields(want, m_item);
                if (bad != "")
                    note_mismatch($sformatf("field(s)%s differ: want %s got %s",
                                            bad, show_item(want), show_item(m_item)));
            end
            if (m_item.kind == KIND_SUMMARY) begin
                n_summaries++;
                if (m_item.status <= ST_BAD_REQ) status_hits[m_item.status]++;
            end else begin
                n_payloads++;
            end
        end
        if (phase_no == HOLD_PHASE && !pressure_done) begin
            hold_left     = HOLD_CYCLES;
            pressure_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    logic [7:0] frame_bytes[$];

    // One byte transfer with optional idle gaps in front. Predicted results
    // are queued (keep) or dropped when the caller supplies its own.
    task automatic send_byte(input logic [7:0] b, input logic fe, input bit keep);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= '{rx_byte: b, frame_end: fe};
        do @(posedge aclk); while (!s_ready);
        n_bytes++;
        if (fe) n_frames++;
        predict_byte(b, fe);
        if (keep) begin
            while (fresh_results.size() != 0) awaited_results.push_back(fresh_results.pop_front());
        end else begin
            fresh_results.delete();
        end
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b1);
    endtask

    // Mostly well-formed requests with random content, some noise and
    // damaged frames mixed in.
    task automatic build_frame();
        logic [7:0]  hdr [0:5];
        logic [15:0] crc;
        int          pick, shape, bc, present, idx;
        frame_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            // line noise
            repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
            return;
        end
        pick = $urandom_range(0, 99);
        hdr[0] = (pick < 40) ? own_addr : (pick < 65) ? 8'h00 : 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70) hdr[1] = $urandom_range(0, 1) ? FC_WRITE_REGS : FC_WRITE_COILS;
        else           hdr[1] = 8'($urandom);
        for (int i = 2; i < 6; i++) hdr[i] = 8'($urandom);

        shape = $urandom_range(0, 99);
        if (shape < 12) begin
            // truncated header
            present = $urandom_range(0, 5);
            for (int i = 0; i < present; i++) frame_bytes.push_back(hdr[i]);
        end else if (shape < 25) begin
            // header only, the read-style shape
            for (int i = 0; i < 6; i++) frame_bytes.push_back(hdr[i]);
        end else begin
            for (int i = 0; i < 6; i++) frame_bytes.push_back(hdr[i]);
            bc = ($urandom_range(0, 99) < 2) ? $urandom_range(200, 255) : $urandom_range(0, 12);
            frame_bytes.push_back(8'(bc));
            present = bc;
            pick = $urandom_range(0, 9);
            if (pick == 0 && present > 0) present--;   // data one short of byte count
            else if (pick == 1)           present++;   // one spare byte past byte count
            repeat (present) frame_bytes.push_back(8'($urandom));
        end

        crc = CRC_INIT;
        foreach (frame_bytes[i]) crc = crc16_step(crc, frame_bytes[i]);
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);

        // occasional bit error anywhere in the frame
        if ($urandom_range(0, 9) == 0) begin
            idx = $urandom_range(0, frame_bytes.size() - 1);
            frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
    endtask

    // Let every pending result drain, then allow for bytes still in the pipe.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // APB write then read-back of own_address.
    task automatic set_own_address(input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= OWN_ADDR_OFFSET;
        pwdata  <= PDATA_W'(v);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);                // write lands on this edge
        own_addr = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[7:0] !== v)
            note_mismatch($sformatf("own_address read back %02h, wrote %02h", prdata[7:0], v));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed script: one row per byte. CRC rows take the running CRC of
    // the frame so far. Typed rows carry the result read straight off the
    // spec; the rest go through the predictor.
    // ------------------------------------------------------------------
    typedef enum logic [1:0] {CRC_NONE, CRC_LO, CRC_HI} crc_fill_t;

    typedef struct {
        logic [7:0] rx_byte;
        logic       frame_end;
        crc_fill_t  fill;
        bit         typed;
        bit         has_result;
        out_item_t  result;
    } script_row_t;

    script_row_t script[$];

    task automatic add_row(input logic [7:0] b, input logic fe, input crc_fill_t fill = CRC_NONE,
                           input bit typed = 1'b0, input bit has_result = 1'b0,
                           input out_item_t result = '0);
        script_row_t row;
        row.rx_byte    = b;
        row.frame_end  = fe;
        row.fill       = fill;
        row.typed      = typed;
        row.has_result = has_result;
        row.result     = result;
        script.push_back(row);
    endtask

    // Summary of a frame with no header bytes: every field zero but kind, status and last.
    function automatic out_item_t bare_summary(input logic [2:0] st);
        out_item_t r;
        r        = '0;
        r.kind   = KIND_SUMMARY;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0]  b;
        logic [15:0] run_crc;
        int          budget;

        // single-byte frames: nothing to check a CRC against
        add_row(8'h00, 1'b1, CRC_NONE, 1'b1, 1'b1, bare_summary(ST_TOO_SHORT));
        add_row(8'hFF, 1'b1, CRC_NONE, 1'b1, 1'b1, bare_summary(ST_TOO_SHORT));
        // two bytes that are not the CRC of an empty body
        add_row(8'h12, 1'b0, CRC_NONE, 1'b1, 1'b0);
        add_row(8'h34, 1'b1, CRC_NONE, 1'b1, 1'b1, bare_summary(ST_CRC_ERR));
        // correct CRC of an empty body, but no header
        add_row(8'hFF, 1'b0, CRC_NONE, 1'b1, 1'b0);
        add_row(8'hFF, 1'b1, CRC_NONE, 1'b1, 1'b1, bare_summary(ST_TOO_SHORT));
        // write multiple registers to us, byte count 4 with only 3 data bytes
        add_row(8'h01, 1'b0);
        add_row(FC_WRITE_REGS, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h05, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h02, 1'b0);
        add_row(8'h04, 1'b0);
        add_row(8'hAA, 1'b0);
        add_row(8'hBB, 1'b0);
        add_row(8'hCC, 1'b0);
        add_row(8'h00, 1'b0, CRC_LO);
        add_row(8'h00, 1'b1, CRC_HI);
        // header-only frame for another slave, extreme field values
        add_row(8'hFF, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0, CRC_LO);
        add_row(8'h00, 1'b1, CRC_HI);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, own_address still at its reset value
        run_crc = CRC_INIT;
        foreach (script[i]) begin
            case (script[i].fill)
                CRC_LO:  b = run_crc[7:0];
                CRC_HI:  b = run_crc[15:8];
                default: begin
                    b       = script[i].rx_byte;
                    run_crc = crc16_step(run_crc, b);
                end
            endcase
            send_byte(b, script[i].frame_end, !script[i].typed);
            if (script[i].typed && script[i].has_result)
                awaited_results.push_back(script[i].result);
            if (script[i].frame_end) run_crc = CRC_INIT;
        end

        // random phases; config changes only once the block has gone quiet
        for (int k = 0; k < N_PHASES; k++) begin
            wait_quiet();
            if (k == N_PHASES - 1) set_own_address(8'($urandom_range(2, 246)));
            else                   set_own_address(8'(own_plan[k]));
            send_idle  = send_plan[k];
            recv_stall = recv_plan[k];
            phase_no   = k;
            if (k == OVF_PHASE) begin
                // runs past the frame size limit
                frame_bytes.delete();
                repeat ($urandom_range(MAX_FRAME_BYTES, MAX_FRAME_BYTES + 8))
                    frame_bytes.push_back(8'($urandom));
                send_frame();
            end
            budget = n_bytes + PHASE_BYTES;
            while (n_bytes < budget) begin
                build_frame();
                send_frame();
            end
        end

        wait_quiet();
        n_errors += awaited_results.size();

        $display("ran %0d bytes, %0d frames, %0d address settings; %0d payload, %0d summary",
                 n_bytes, n_frames, N_PHASES, n_payloads, n_summaries);
        $display("status mix: good %0d ovf %0d crc %0d short %0d not-addr %0d bad-req %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5]);
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### modbus_rtu_request_receiver.f
rtl/mrr_pkg.sv
rtl/mrr_frame.sv
rtl/mrr_result_fifo.sv
rtl/modbus_rtu_request_receiver.sv
bench/tb.sv
